// ===== rtl/lfsa_pkg.sv =====
`default_nettype none

package lfsa_pkg;

  // pool depth
  localparam int MAX_SERVERS = 64;

  // field widths
  localparam int TIME_W = 32;
  localparam int AMT_W  = 32;
  localparam int DUR_W  = 32;
  localparam int TOT_W  = 48;
  localparam int REL_W  = TIME_W + 1;
  localparam int SIDX_W = 6;
  localparam int CFG_W  = 7;

  // cell numbering
  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CMP_W = IDX_W + CFG_W;

  localparam logic [CFG_W-1:0] POOL_RESET = CFG_W'(64);
  localparam logic [TOT_W-1:0] TOTAL_MAX  = {TOT_W{1'b1}};

  // request codes
  localparam logic FUNC_ARRIVAL = 1'b0;
  localparam logic FUNC_READ    = 1'b1;

  typedef struct packed {
    logic              func;
    logic [TIME_W-1:0] arrival_time;
    logic [AMT_W-1:0]  amount;
    logic [DUR_W-1:0]  hold_duration;
    logic [SIDX_W-1:0] read_index;
  } in_req_t;

  typedef struct packed {
    logic              granted;
    logic [SIDX_W-1:0] server_index;
    logic [TOT_W-1:0]  server_total;
  } out_res_t;

  // request as it travels down the chain
  typedef struct packed {
    in_req_t          req;
    logic             done;
    out_res_t         res;
  } chain_msg_t;

endpackage

`default_nettype wire

// ===== rtl/lfsa_cell.sv =====
`default_nettype none

module lfsa_cell (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [lfsa_pkg::IDX_W-1:0] cell_idx,
  input  wire logic [lfsa_pkg::CFG_W-1:0] pool,
  input  wire logic                     vld_in,
  input  wire lfsa_pkg::chain_msg_t     msg_in,
  output logic                          vld_out,
  output lfsa_pkg::chain_msg_t          msg_out
);

  import lfsa_pkg::*;

  logic [REL_W-1:0]       rel_r;
  logic [REL_W-1:0]       rel_nxt;
  logic [TOT_W-1:0]       tot_r;
  logic [TOT_W-1:0]       tot_nxt;
  logic                   vld_r;
  chain_msg_t             msg_r;
  chain_msg_t             msg_nxt;

  logic                   is_free;
  logic                   eligible;
  logic                   grant;
  logic                   hit;
  logic [TOT_W:0]         sum;
  logic [TOT_W-1:0]       sat;
  logic [IDX_W+SIDX_W-1:0] idx_wide;

  always_comb begin
    is_free  = (rel_r <= {1'b0, msg_in.req.arrival_time});
    eligible = (CMP_W'(cell_idx) < CMP_W'(pool));
    grant    = vld_in && (msg_in.req.func == FUNC_ARRIVAL) && !msg_in.done
               && eligible && is_free;
    hit      = vld_in && (msg_in.req.func == FUNC_READ)
               && (CMP_W'(cell_idx) == CMP_W'(msg_in.req.read_index));
    sum      = {1'b0, tot_r} + (TOT_W+1)'(msg_in.req.amount);
    sat      = sum[TOT_W] ? TOTAL_MAX : sum[TOT_W-1:0];
    idx_wide = (IDX_W+SIDX_W)'(cell_idx);

    msg_nxt = msg_in;
    rel_nxt = rel_r;
    tot_nxt = tot_r;
    if (grant) begin
      msg_nxt.done             = 1'b1;
      msg_nxt.res.granted      = 1'b1;
      msg_nxt.res.server_index = idx_wide[SIDX_W-1:0];
      msg_nxt.res.server_total = sat;
      rel_nxt = {1'b0, msg_in.req.arrival_time} + REL_W'(msg_in.req.hold_duration);
      tot_nxt = sat;
    end else if (hit) begin
      msg_nxt.res.server_total = tot_r;
    end
  end

  // server state, cleared at reset: every server free with zero total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rel_r <= '0;
      tot_r <= '0;
      vld_r <= 1'b0;
    end else begin
      rel_r <= rel_nxt;
      tot_r <= tot_nxt;
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    msg_r <= msg_nxt;
  end

  assign vld_out = vld_r;
  assign msg_out = msg_r;

endmodule

`default_nettype wire

// ===== rtl/lowest_free_server_assign_core.sv =====
`default_nettype none

// channel  | ports                                  | handshake
// ---------+----------------------------------------+------------------------------
// request  | start, busy, in_req                    | taken when start & !busy
// result   | out_valid, out_res                     | one-cycle strobe, no backpressure
// config   | cfg_valid, cfg_ready, cfg_servers_in_use | written when cfg_valid & cfg_ready
//
// one request at a time: a request walks the row of MAX_SERVERS cells, one cell per cycle,
// through the input register and then each cell register in turn, and the next request
// can be taken the cycle after its result strobe
// each cell holds one server and is visited once
// synchronous active-low reset frees every server and zeroes every total at once
// the receiver cannot stall; results are never held back

module lowest_free_server_assign_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire lfsa_pkg::in_req_t         in_req,
  output logic                           out_valid,
  output lfsa_pkg::out_res_t             out_res,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [lfsa_pkg::CFG_W-1:0] cfg_servers_in_use
);

  import lfsa_pkg::*;

  logic             busy_r;
  logic             busy_nxt;
  logic [CFG_W-1:0] pool_r;
  logic [CFG_W-1:0] pool_nxt;
  logic             in_vld_r;
  chain_msg_t       in_msg_r;
  chain_msg_t       in_msg_nxt;
  logic             accept;

  // chain taps: index 0 feeds the first cell, last index leaves the row
  logic             chain_vld [MAX_SERVERS+1];
  chain_msg_t       chain_msg [MAX_SERVERS+1];

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  always_comb begin
    // busy from acceptance until the result strobe
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (chain_vld[MAX_SERVERS]) begin
      busy_nxt = 1'b0;
    end

    pool_nxt = pool_r;
    if (cfg_valid && cfg_ready) begin
      pool_nxt = cfg_servers_in_use;
    end

    // a dropped arrival reports zeros, a read echoes its index
    in_msg_nxt.req              = in_req;
    in_msg_nxt.done             = 1'b0;
    in_msg_nxt.res.granted      = 1'b0;
    in_msg_nxt.res.server_index = (in_req.func == FUNC_READ) ? in_req.read_index : '0;
    in_msg_nxt.res.server_total = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      pool_r   <= POOL_RESET;
      in_vld_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      pool_r   <= pool_nxt;
      in_vld_r <= accept;
    end
  end

  // request payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      in_msg_r <= in_msg_nxt;
    end
  end

  assign chain_vld[0] = in_vld_r;
  assign chain_msg[0] = in_msg_r;

  // one cell per server; the first free eligible cell marks the request done
  for (genvar g = 0; g < MAX_SERVERS; g++) begin : g_cell
    lfsa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(g)),
      .pool     (pool_r),
      .vld_in   (chain_vld[g]),
      .msg_in   (chain_msg[g]),
      .vld_out  (chain_vld[g+1]),
      .msg_out  (chain_msg[g+1])
    );
  end

  // last cell output is registered, so it drives the result ports directly
  assign out_valid = chain_vld[MAX_SERVERS];
  assign out_res   = chain_msg[MAX_SERVERS].res;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

// checks lowest_free_server_assign_core against a cycle-free model of the server pool
// requests go in one at a time through start/busy; each request yields one result strobe
// the pool count is rewritten between phases, only once every result has come back
module testbench;
  import lfsa_pkg::*;

  // quiet cycles allowed before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [TIME_W-1:0] TIME_TOP = {TIME_W{1'b1}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_req_t in_req = '0;
  logic out_valid;
  out_res_t out_res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_servers_in_use = '0;

  lowest_free_server_assign_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_req             (in_req),
    .out_valid          (out_valid),
    .out_res            (out_res),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_servers_in_use (cfg_servers_in_use)
  );

  // model of the pool: release time and running total per server
  logic [REL_W-1:0] free_at [MAX_SERVERS];
  logic [TOT_W-1:0] credit [MAX_SERVERS];
  logic [CFG_W-1:0] pool_count;

  out_res_t expected_results[$];
  out_res_t want;
  int mismatches = 0;
  int quiet_cycles = 0;
  int sender_idle_pct = 0;
  // running arrival clock for the in-order sequences
  logic [TIME_W-1:0] arrival_clock = '0;

  initial begin
    forever #10 clk = ~clk;
  end

  // grant to the lowest free server, or drop; reads just look up a total
  function automatic out_res_t allocate_server(in_req_t req);
    out_res_t res;
    int limit;
    logic [TOT_W:0] sum;
    res = '0;
    if (req.func == FUNC_READ) begin
      res.server_index = req.read_index;
      res.server_total = credit[req.read_index];
      return res;
    end
    // counts above the pool depth saturate
    limit = (pool_count > MAX_SERVERS) ? MAX_SERVERS : int'(pool_count);
    for (int i = 0; i < limit; i++) begin
      if (free_at[i] <= {1'b0, req.arrival_time}) begin
        sum = credit[i] + req.amount;
        credit[i] = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOT_W-1:0];
        free_at[i] = REL_W'(req.arrival_time) + REL_W'(req.hold_duration);
        res.granted = 1'b1;
        res.server_index = i[SIDX_W-1:0];
        res.server_total = credit[i];
        return res;
      end
    end
    // no free server: dropped arrival gives an all-zero result
    return res;
  endfunction

  function automatic in_req_t arrival(logic [TIME_W-1:0] t, logic [AMT_W-1:0] amt,
                                      logic [DUR_W-1:0] dur);
    in_req_t req;
    req.func = FUNC_ARRIVAL;
    req.arrival_time = t;
    req.amount = amt;
    req.hold_duration = dur;
    // index is don't-care for arrivals, keep it noisy
    req.read_index = SIDX_W'($urandom);
    return req;
  endfunction

  function automatic in_req_t read_of(logic [SIDX_W-1:0] idx);
    in_req_t req;
    req.func = FUNC_READ;
    req.arrival_time = $urandom;
    req.amount = $urandom;
    req.hold_duration = $urandom;
    req.read_index = idx;
    return req;
  endfunction

  // present one request, optionally after an idle gap, and wait for it to be taken
  // start is left high afterwards so back-to-back requests need no toggle
  task automatic send_request(in_req_t req);
    int gap;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      gap = $urandom_range(1, 70);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
    expected_results.insert(expected_results.size(), allocate_server(req));
  endtask

  // drop start and wait until every outstanding result has arrived
  task automatic wait_drain();
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic write_pool_count(logic [CFG_W-1:0] count);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_servers_in_use <= count;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pool_count = count;
  endtask

  // lowest-index choice, zero duration, same-time reuse, reads of touched and untouched servers
  task automatic test_first_free_server();
    sender_idle_pct = 0;
    send_request(arrival(0, 0, 0));
    send_request(arrival(0, {AMT_W{1'b1}}, 10));
    send_request(arrival(0, 1, 5));
    send_request(arrival(5, 7, 0));
    send_request(arrival(5, 3, 0));
    send_request(read_of(0));
    send_request(read_of(1));
    send_request(read_of(SIDX_W'(MAX_SERVERS - 1)));
  endtask

  // pool of one, pool of zero, count above the depth
  task automatic test_pool_count();
    write_pool_count(CFG_W'(1));
    send_request(arrival(6, 2, 100));
    send_request(arrival(10, 2, 100));
    write_pool_count(CFG_W'(0));
    send_request(arrival(500, 9, 0));
    write_pool_count({CFG_W{1'b1}});
    send_request(arrival(500, 4, 1000));
    send_request(arrival(500, 4, 1000));
    send_request(read_of(2));
    write_pool_count(POOL_RESET);
  endtask

  // an arrival earlier than the previous one is judged on release times alone
  task automatic test_out_of_order();
    send_request(arrival(900, 5, 50));
    send_request(arrival(20, 5, 0));
    send_request(arrival(1600, 1, 0));
    send_request(read_of(SIDX_W'($urandom)));
  endtask

  // mostly in-order arrivals with random content, some reads and some out-of-order noise
  task automatic run_random_phase(int count, int idle_pct, logic [CFG_W-1:0] pool);
    in_req_t req;
    int eff;
    int pick;
    logic [TIME_W-1:0] t;
    logic [DUR_W-1:0] dur;
    logic [AMT_W-1:0] amt;
    write_pool_count(pool);
    sender_idle_pct = idle_pct;
    eff = (pool > MAX_SERVERS) ? MAX_SERVERS : int'(pool);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      // occasional pause until the pipe is empty
      if ($urandom_range(0, 99) < 2) wait_drain();
      if (pick < 10) begin
        req = read_of(SIDX_W'($urandom));
      end else begin
        // durations scaled to the pool so it fills and empties
        dur = $urandom_range(0, 8 * eff + 8);
        amt = $urandom;
        if ($urandom_range(0, 19) == 0) amt = 0;
        if ($urandom_range(0, 19) == 0) amt = {AMT_W{1'b1}};
        if (pick < 15) begin
          // out-of-order noise, a little behind the running clock
          t = (arrival_clock > 30) ? arrival_clock - $urandom_range(0, 30) : 0;
        end else begin
          arrival_clock = arrival_clock + $urandom_range(0, 8);
          t = arrival_clock;
        end
        req = arrival(t, amt, dur);
      end
      send_request(req);
    end
  endtask

  // top of the time range: release times that need the extra bit
  task automatic test_time_extremes();
    write_pool_count(POOL_RESET);
    sender_idle_pct = 0;
    send_request(arrival(TIME_TOP, {AMT_W{1'b1}}, {DUR_W{1'b1}}));
    send_request(arrival(TIME_TOP, 1, 1));
    send_request(arrival(TIME_TOP, 0, 0));
    send_request(arrival(0, 1, {DUR_W{1'b1}}));
    send_request(read_of(0));
    send_request(read_of(1));
    send_request(read_of(2));
  endtask

  // result checker: every strobe must match the oldest outstanding prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none pending, expected none actual %h", $time, out_res);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (want.granted !== out_res.granted) begin
          $display("%0t: granted expected %0d actual %0d", $time, want.granted,
                   out_res.granted);
          mismatches++;
        end
        if (want.server_index !== out_res.server_index) begin
          $display("%0t: server_index expected %0d actual %0d", $time, want.server_index,
                   out_res.server_index);
          mismatches++;
        end
        if (want.server_total !== out_res.server_total) begin
          $display("%0t: server_total expected %h actual %h", $time, want.server_total,
                   out_res.server_total);
          mismatches++;
        end
      end
    end
  end

  // watchdog: any request, result or config write counts as progress
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    // model starts in the reset state
    pool_count = POOL_RESET;
    for (int i = 0; i < MAX_SERVERS; i++) begin
      free_at[i] = '0;
      credit[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_free_server();
    test_pool_count();
    test_out_of_order();

    arrival_clock = 2000;
    run_random_phase(400, 0, POOL_RESET);
    run_random_phase(250, 49, CFG_W'(1));
    run_random_phase(300, 26, CFG_W'(4));
    run_random_phase(300, 49, {CFG_W{1'b1}});
    run_random_phase(50, 26, CFG_W'(0));
    run_random_phase(300, 0, CFG_W'($urandom_range(2, MAX_SERVERS - 1)));
    run_random_phase(300, 26, CFG_W'(MAX_SERVERS + 1));

    test_time_extremes();

    // drain, then give the row time to show any stray strobe
    wait_drain();
    repeat (MAX_SERVERS + 4) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lfsa_pkg.sv
rtl/lfsa_cell.sv
rtl/lowest_free_server_assign_core.sv
tb/testbench.sv
